FILE: rtl/pssa_pkg.sv
`default_nettype none

package pssa_pkg;

  localparam int NUM_SLOTS = 32;

  localparam int OFS_W  = 24;
  localparam int OPC_W  = 3;
  localparam int SLOT_W = 5;
  localparam int STS_W  = 4;
  localparam int CNT_W  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [OPC_W-1:0] OP_ALLOC_SLOT  = 3'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC_SPACE = 3'd1;
  localparam logic [OPC_W-1:0] OP_MARK_VALID  = 3'd2;
  localparam logic [OPC_W-1:0] OP_MARK_DEL    = 3'd3;
  localparam logic [OPC_W-1:0] OP_SLOT_ADDR   = 3'd4;
  localparam logic [OPC_W-1:0] OP_RAW_ADDR    = 3'd5;
  localparam logic [OPC_W-1:0] OP_QUERY       = 3'd6;

  localparam logic [STS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STS_W-1:0] ST_NO_SLOT     = 4'd1;
  localparam logic [STS_W-1:0] ST_NO_SPACE    = 4'd2;
  localparam logic [STS_W-1:0] ST_UNALLOC     = 4'd3;
  localparam logic [STS_W-1:0] ST_SPACE_EXIST = 4'd4;
  localparam logic [STS_W-1:0] ST_NO_SPACE_YET = 4'd5;
  localparam logic [STS_W-1:0] ST_ALREADY_VLD = 4'd6;
  localparam logic [STS_W-1:0] ST_NOT_VALID   = 4'd7;
  localparam logic [STS_W-1:0] ST_RANGE       = 4'd8;
  localparam logic [STS_W-1:0] ST_BAD_SLOT    = 4'd9;
  localparam logic [STS_W-1:0] ST_BASE_INV    = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_BASE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC_VALID  = 2'd3;

  localparam logic [OFS_W-1:0] REGION_RST   = 24'd1048576;
  localparam logic [OFS_W-1:0] RESERVED_RST = 24'd4096;

  // per-slot flags kept in memory; slot-allocated lives in flops
  typedef struct packed {
    logic deleted;
    logic valid;
    logic space;
  } flags_t;

endpackage

`default_nettype wire

FILE: rtl/pssa_in_if.sv
`default_nettype none

interface pssa_in_if import pssa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [SLOT_W-1:0] slot_index;
  logic [OFS_W-1:0]  byte_count;
  logic [OFS_W-1:0]  byte_offset;

  modport source (output valid, opcode, slot_index, byte_count, byte_offset, input ready);
  modport sink   (input valid, opcode, slot_index, byte_count, byte_offset, output ready);
endinterface

`default_nettype wire

FILE: rtl/pssa_out_if.sv
`default_nettype none

interface pssa_out_if import pssa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [SLOT_W-1:0] slot_found;
  logic [OFS_W-1:0]  value;
  logic [CNT_W-1:0]  free_slot_count;

  modport source (output valid, status, slot_found, value, free_slot_count, input ready);
  modport sink   (input valid, status, slot_found, value, free_slot_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/program_slot_space_allocator.sv
// Items are latched with their table entries on acceptance; the result register
// loads in S_EXEC. Items do not overlap (table read, then modify/write); a new
// item is taken while a result waits, then held until that result is taken.
// Reset (async, active low): all slots free, free pointer at 4096, registers at
// their defaults; slot memories need no clearing, allocated bits qualify them.
`default_nettype none

module program_slot_space_allocator import pssa_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [OFS_W-1:0]       cfg_data_i,
  pssa_in_if.sink                in_i,
  pssa_out_if.source             out_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [8:0] NS = 9'(NUM_SLOTS);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  state_e state_q;

  // config
  logic [OFS_W-1:0] region_q, exec_base_q;
  logic             exec_vld_q;

  // control state
  logic [NUM_SLOTS-1:0] alloc_q, alloc_d;
  logic [OFS_W-1:0]     fp_q, fp_d;
  logic [CW-1:0]        unalloc_q, unalloc_d;

  // latched item
  logic [OPC_W-1:0]  opc_q;
  logic [SLOT_W-1:0] slot_q;
  logic [OFS_W-1:0]  cnt_q, ofs_q;

  // memories
  flags_t           flag_mem [NUM_SLOTS];
  logic [OFS_W-1:0] start_mem [NUM_SLOTS];
  flags_t           flag_rd_q;
  logic [OFS_W-1:0] start_rd_q;

  // result register
  logic              out_valid_q;
  logic [STS_W-1:0]  sts_q, sts_d;
  logic [SLOT_W-1:0] found_q, found_d;
  logic [OFS_W-1:0]  val_q, val_d;
  logic [CNT_W-1:0]  fcnt_q;

  logic          in_fire, exec_go;
  logic [IW-1:0] rd_addr, addr_q;
  logic          slot_ok, alloc_bit;
  flags_t        fl;
  logic [IW-1:0] ff_idx;
  logic          ff_hit;
  logic [OFS_W-1:0] free_bytes;
  logic [OFS_W:0]   sum;
  logic [OFS_W-1:0] base;
  logic          flag_we, start_we;
  logic [IW-1:0] flag_waddr;
  flags_t        flag_wdata;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && (state_q == S_IDLE);
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);
  assign rd_addr    = IW'(in_i.slot_index);
  assign addr_q     = IW'(slot_q);

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = sts_q;
  assign out_o.slot_found      = found_q;
  assign out_o.value           = val_q;
  assign out_o.free_slot_count = fcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q    <= REGION_RST;
      exec_base_q <= '0;
      exec_vld_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REGION_SIZE: region_q    <= cfg_data_i;
        REG_EXEC_BASE:   exec_base_q <= cfg_data_i;
        REG_EXEC_VALID:  exec_vld_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      opc_q      <= in_i.opcode;
      slot_q     <= in_i.slot_index;
      cnt_q      <= in_i.byte_count;
      ofs_q      <= in_i.byte_offset;
      flag_rd_q  <= flag_mem[rd_addr];
      start_rd_q <= start_mem[rd_addr];
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (start_we) begin
      start_mem[addr_q] <= fp_q;
    end
    if (exec_go) begin
      sts_q   <= sts_d;
      found_q <= found_d;
      val_q   <= val_d;
      fcnt_q  <= CNT_W'(unalloc_d);
    end
  end

  always_comb begin
    slot_ok   = {4'b0, slot_q} < NS;
    alloc_bit = slot_ok && alloc_q[addr_q];
    fl        = alloc_bit ? flag_rd_q : '0;

    ff_hit = 1'b0;
    ff_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        ff_hit = 1'b1;
        ff_idx = IW'(i);
      end
    end

    free_bytes = (region_q > fp_q) ? (region_q - fp_q) : '0;
    base       = (opc_q == OP_RAW_ADDR) ? exec_base_q : start_rd_q;
    sum        = {1'b0, base} + {1'b0, ofs_q};

    alloc_d    = alloc_q;
    fp_d       = fp_q;
    unalloc_d  = unalloc_q;
    sts_d      = ST_OK;
    found_d    = '0;
    val_d      = '0;
    flag_we    = 1'b0;
    start_we   = 1'b0;
    flag_waddr = addr_q;
    flag_wdata = fl;

    case (opc_q)
      OP_ALLOC_SLOT: begin
        if (!ff_hit) begin
          sts_d = ST_NO_SLOT;
        end else begin
          alloc_d[ff_idx] = 1'b1;
          if (unalloc_q != '0) unalloc_d = unalloc_q - 1'b1;
          found_d    = SLOT_W'(ff_idx);
          flag_we    = 1'b1;
          flag_waddr = ff_idx;
          flag_wdata = '0;
        end
      end
      OP_ALLOC_SPACE: begin
        if (!slot_ok) sts_d = ST_BAD_SLOT;
        else if (free_bytes < cnt_q) sts_d = ST_NO_SPACE;
        else if (!alloc_bit) sts_d = ST_UNALLOC;
        else if (fl.space) sts_d = ST_SPACE_EXIST;
        else begin
          flag_we          = 1'b1;
          flag_wdata.space = 1'b1;
          start_we         = 1'b1;
          val_d            = fp_q;
          fp_d             = fp_q + cnt_q;
        end
      end
      OP_MARK_VALID: begin
        if (!slot_ok) sts_d = ST_BAD_SLOT;
        else if (!fl.space) sts_d = ST_NO_SPACE_YET;
        else if (fl.valid) sts_d = ST_ALREADY_VLD;
        else begin
          flag_we          = 1'b1;
          flag_wdata.valid = 1'b1;
        end
      end
      OP_MARK_DEL: begin
        if (!slot_ok) sts_d = ST_BAD_SLOT;
        else if (!fl.valid || fl.deleted) sts_d = ST_NOT_VALID;
        else begin
          flag_we            = 1'b1;
          flag_wdata.deleted = 1'b1;
        end
      end
      OP_SLOT_ADDR: begin
        if (!slot_ok) sts_d = ST_BAD_SLOT;
        else if (!fl.valid || fl.deleted) sts_d = ST_NOT_VALID;
        else if (sum > {1'b0, region_q}) sts_d = ST_RANGE;
        else val_d = sum[OFS_W-1:0];
      end
      OP_RAW_ADDR: begin
        if (!exec_vld_q) sts_d = ST_BASE_INV;
        else if (sum > {1'b0, region_q}) sts_d = ST_RANGE;
        else val_d = sum[OFS_W-1:0];
      end
      OP_QUERY: begin
        val_d = free_bytes;
      end
      default: ;
    endcase

    if (!exec_go) begin
      flag_we  = 1'b0;
      start_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      alloc_q     <= '0;
      fp_q        <= RESERVED_RST;
      unalloc_q   <= CW'(NUM_SLOTS);
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_EXEC;
          if (out_o.ready) out_valid_q <= 1'b0;
        end
        S_EXEC: begin
          if (exec_go) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            alloc_q     <= alloc_d;
            fp_q        <= fp_d;
            unalloc_q   <= unalloc_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
